FILE: rtl/core/pbaxc_pkg.sv
package pbaxc_pkg;

    // op codes
    localparam logic [2:0] OP_PUBLISH = 3'd0;
    localparam logic [2:0] OP_FRAME   = 3'd1;
    localparam logic [2:0] OP_QDOWN   = 3'd2;
    localparam logic [2:0] OP_QUP     = 3'd3;
    localparam logic [2:0] OP_QAXIS   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LOOK_SCALE  = 2'd0;
    localparam logic [1:0] CFG_LOOK_EXPO   = 2'd1;
    localparam logic [1:0] CFG_FIRE_STICKY = 2'd2;

    localparam logic [15:0] LOOK_SCALE_RST  = 16'd4096;
    localparam logic [16:0] LOOK_EXPO_RST   = 17'd36045;
    localparam logic        FIRE_STICKY_RST = 1'b1;

    localparam int BTN_W  = 11;
    localparam int N_AXES = 4;

    // query indexes
    localparam logic [3:0] LAST_BUTTON = 4'd10;
    localparam logic [3:0] FIRE_BUTTON = 4'd0;
    localparam logic [3:0] AXIS_LX     = 4'd11;
    localparam logic [3:0] AXIS_LY     = 4'd12;
    localparam logic [3:0] AXIS_RX     = 4'd13;
    localparam logic [3:0] AXIS_RY     = 4'd14;

    // dead zone: 0.16 of full scale, rescale by 32768 / (32768 - dead zone)
    localparam logic [15:0] DZ_THRESH = 16'd5243;
    localparam longint unsigned DZ_SPAN  = 64'd32768 - 64'd5243;
    localparam int              DZ_SHIFT = 30;
    localparam longint unsigned DZ_RECIP_FULL =
        ((64'd1 << (DZ_SHIFT + 15)) + DZ_SPAN - 64'd1) / DZ_SPAN;
    localparam logic [30:0] DZ_RECIP = 31'(DZ_RECIP_FULL);

    localparam logic [16:0] EXPO_ONE = 17'd65536;
    localparam logic [14:0] AXIS_MAX = 15'h7fff;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [10:0]        button_level;
        logic               enabled;
        logic [3:0]         input_index;
    } t_in_item;

    typedef struct packed {
        logic               flag;
        logic signed [15:0] axis_value;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       dz_issue;
        logic [1:0] dz_sel;
        logic       pub_commit;
        logic       frame;
        logic       btn_query;
        logic       ax_out;
    } t_cmd;

endpackage

FILE: rtl/core/pbaxc_ctrl.sv
module pbaxc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [2:0]         i_op,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pbaxc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DZ,
        S_PUB,
        S_FRAME,
        S_BTN,
        S_AX1,
        S_AX2,
        S_AX3,
        S_AX4,
        S_AXOUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    pbaxc_pkg::t_cmd cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        cmd.dz_sel = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    case (i_op)
                        pbaxc_pkg::OP_PUBLISH: n_state = S_DZ;
                        pbaxc_pkg::OP_FRAME:   n_state = S_FRAME;
                        pbaxc_pkg::OP_QDOWN:   n_state = S_BTN;
                        pbaxc_pkg::OP_QUP:     n_state = S_BTN;
                        pbaxc_pkg::OP_QAXIS:   n_state = S_AX1;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_DZ: begin
                cmd.dz_issue = 1'b1;
                if (r_cnt == 2'(pbaxc_pkg::N_AXES - 1)) begin
                    n_cnt   = 2'd0;
                    n_state = S_PUB;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_PUB: begin
                cmd.pub_commit = 1'b1;
                n_state        = S_IDLE;
            end
            S_FRAME: begin
                cmd.frame = 1'b1;
                n_state   = S_IDLE;
            end
            S_BTN: begin
                if (out_free) begin
                    cmd.btn_query = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_AX1: n_state = S_AX2;
            S_AX2: n_state = S_AX3;
            S_AX3: n_state = S_AX4;
            S_AX4: n_state = S_AXOUT;
            S_AXOUT: begin
                if (out_free) begin
                    cmd.ax_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (cmd.btn_query || cmd.ax_out) ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef ASSERT_OFF
    a_cnt_only_in_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DZ) |-> (r_cnt == 2'd0))
        else $error("axis counter left non-zero outside dead-zone pass");

    a_pub_after_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUB) |-> $past(r_state == S_DZ && r_cnt == 2'd3))
        else $error("publish commit without all four axes issued");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_BTN || r_state == S_AXOUT))
        else $error("result beat raised outside a query state");
`endif

endmodule

FILE: rtl/core/pbaxc_dp.sv
module pbaxc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pbaxc_pkg::t_cmd       i_cmd,
    input  pbaxc_pkg::t_in_item   i_in_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [16:0]           i_cfg_data,
    output pbaxc_pkg::t_out_item  o_out_data
);

    pbaxc_pkg::t_in_item  r_item;
    pbaxc_pkg::t_out_item r_out;

    // configuration
    logic [15:0] r_look_scale;
    logic [16:0] r_look_expo;
    logic        r_fire_sticky;

    // button state
    logic [10:0] r_pub_level,  n_pub_level;
    logic [10:0] r_pend_down,  n_pend_down;
    logic [10:0] r_pend_up,    n_pend_up;
    logic [10:0] r_prev_level, n_prev_level;
    logic [10:0] r_frame_level, n_frame_level;
    logic [10:0] r_down_latch, n_down_latch;
    logic [10:0] r_up_latch,   n_up_latch;
    logic [10:0] r_down_rmask, n_down_rmask;
    logic [10:0] r_up_rmask,   n_up_rmask;
    logic        r_fire_dlv,   n_fire_dlv;

    // axis state
    logic [15:0] r_pub_axes   [pbaxc_pkg::N_AXES];
    logic [15:0] n_pub_axes   [pbaxc_pkg::N_AXES];
    logic [15:0] r_frame_axes [pbaxc_pkg::N_AXES];
    logic [15:0] n_frame_axes [pbaxc_pkg::N_AXES];

    // dead-zone pipe
    logic        r_dz_valid;
    logic [45:0] r_dz_prod;
    logic        r_dz_zero;
    logic        r_dz_neg;
    logic [1:0]  r_dz_idx;
    logic [15:0] dz_raw;
    logic [15:0] dz_mag;
    logic [14:0] dz_diff;
    logic [45:0] dz_prod;
    logic [15:0] dz_q;
    logic [14:0] dz_sat;
    logic [15:0] dz_val;

    // view axis pipe
    logic [15:0] lk_v;
    logic [15:0] lk_mag;
    logic [16:0] lk_e;
    logic [15:0] r_lk_a;
    logic        r_lk_neg;
    logic [16:0] r_lk_ome;
    logic [32:0] r_lk_ea;
    logic [31:0] r_lk_bracket;
    logic [31:0] r_lk_p2;
    logic [20:0] r_lk_p3;
    logic [47:0] lk_prod2;
    logic [47:0] lk_prod3;
    logic [14:0] lk_sat;
    logic [15:0] lk_val;

    // query decode
    logic [10:0] btn_bit;
    logic [10:0] level_in;
    logic        down_hit;
    logic        up_hit;
    logic        sticky;
    logic        btn_flag;
    logic [15:0] axis_res;

    // button query
    assign btn_bit  = (r_item.input_index <= pbaxc_pkg::LAST_BUTTON)
                    ? (11'd1 << r_item.input_index) : 11'd0;
    assign level_in = r_item.enabled ? r_item.button_level : 11'd0;
    assign down_hit = |(r_down_latch & btn_bit);
    assign up_hit   = |(r_up_latch & btn_bit);
    assign sticky   = (r_item.input_index == pbaxc_pkg::FIRE_BUTTON) && r_fire_sticky
                    && r_fire_dlv && !r_frame_level[0];
    assign btn_flag = (r_item.op == pbaxc_pkg::OP_QDOWN) ? down_hit : (up_hit || sticky);

    // dead zone, first step: magnitude and reciprocal product
    always_comb begin
        case (i_cmd.dz_sel)
            2'd0:    dz_raw = r_item.left_x;
            2'd1:    dz_raw = r_item.left_y;
            2'd2:    dz_raw = r_item.right_x;
            default: dz_raw = r_item.right_y;
        endcase
    end

    assign dz_mag  = dz_raw[15] ? (~dz_raw + 16'd1) : dz_raw;
    assign dz_diff = 15'(dz_mag - pbaxc_pkg::DZ_THRESH);
    assign dz_prod = 46'(dz_diff) * 46'(pbaxc_pkg::DZ_RECIP);

    // second step: quotient, clamp, sign
    assign dz_q   = r_dz_prod[45:30];
    assign dz_sat = dz_q[15] ? pbaxc_pkg::AXIS_MAX : dz_q[14:0];
    assign dz_val = r_dz_zero ? 16'd0
                  : (r_dz_neg ? (16'd0 - {1'b0, dz_sat}) : {1'b0, dz_sat});

    // view axis shaping
    assign lk_v     = (r_item.input_index == pbaxc_pkg::AXIS_RY) ? r_frame_axes[3]
                                                                 : r_frame_axes[2];
    assign lk_mag   = lk_v[15] ? (~lk_v + 16'd1) : lk_v;
    assign lk_e     = (r_look_expo > pbaxc_pkg::EXPO_ONE) ? pbaxc_pkg::EXPO_ONE : r_look_expo;
    assign lk_prod2 = 48'(r_lk_a) * 48'(r_lk_bracket);
    assign lk_prod3 = 48'(r_lk_p2) * 48'(r_look_scale);
    assign lk_sat   = (|r_lk_p3[20:15]) ? pbaxc_pkg::AXIS_MAX : r_lk_p3[14:0];
    assign lk_val   = r_lk_neg ? (16'd0 - {1'b0, lk_sat}) : {1'b0, lk_sat};

    always_comb begin
        case (r_item.input_index)
            pbaxc_pkg::AXIS_LX: axis_res = r_frame_axes[0];
            pbaxc_pkg::AXIS_LY: axis_res = 16'd0 - r_frame_axes[1];
            pbaxc_pkg::AXIS_RX: axis_res = lk_val;
            pbaxc_pkg::AXIS_RY: axis_res = lk_val;
            default:            axis_res = 16'd0;
        endcase
    end

    // state update
    always_comb begin
        n_pub_level   = r_pub_level;
        n_pend_down   = r_pend_down;
        n_pend_up     = r_pend_up;
        n_prev_level  = r_prev_level;
        n_frame_level = r_frame_level;
        n_down_latch  = r_down_latch;
        n_up_latch    = r_up_latch;
        n_down_rmask  = r_down_rmask;
        n_up_rmask    = r_up_rmask;
        n_fire_dlv    = r_fire_dlv;
        for (int i = 0; i < pbaxc_pkg::N_AXES; i++) begin
            n_pub_axes[i]   = r_pub_axes[i];
            n_frame_axes[i] = r_frame_axes[i];
        end

        if (r_dz_valid) begin
            n_pub_axes[r_dz_idx] = dz_val;
        end

        if (i_cmd.pub_commit) begin
            n_pend_down = r_pend_down | (level_in & ~r_pub_level);
            n_pend_up   = r_pend_up | (r_pub_level & ~level_in);
            n_pub_level = level_in;
        end

        if (i_cmd.frame) begin
            n_frame_level = r_pub_level;
            n_prev_level  = r_pub_level;
            n_pend_down   = 11'd0;
            n_pend_up     = 11'd0;
            n_down_latch  = (r_down_latch & ~r_down_rmask) | r_pend_down
                          | (r_pub_level & ~r_prev_level);
            n_up_latch    = (r_up_latch & ~r_up_rmask) | r_pend_up
                          | (r_prev_level & ~r_pub_level);
            n_down_rmask  = 11'd0;
            n_up_rmask    = 11'd0;
            for (int i = 0; i < pbaxc_pkg::N_AXES; i++) begin
                n_frame_axes[i] = r_pub_axes[i];
            end
        end

        if (i_cmd.btn_query) begin
            if (r_item.op == pbaxc_pkg::OP_QDOWN && down_hit) begin
                n_down_rmask = r_down_rmask | btn_bit;
                if (r_item.input_index == pbaxc_pkg::FIRE_BUTTON) begin
                    n_fire_dlv = 1'b1;
                end
            end
            if (r_item.op == pbaxc_pkg::OP_QUP && up_hit) begin
                n_up_rmask = r_up_rmask | btn_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_scale  <= pbaxc_pkg::LOOK_SCALE_RST;
            r_look_expo   <= pbaxc_pkg::LOOK_EXPO_RST;
            r_fire_sticky <= pbaxc_pkg::FIRE_STICKY_RST;
            r_pub_level   <= 11'd0;
            r_pend_down   <= 11'd0;
            r_pend_up     <= 11'd0;
            r_prev_level  <= 11'd0;
            r_frame_level <= 11'd0;
            r_down_latch  <= 11'd0;
            r_up_latch    <= 11'd0;
            r_down_rmask  <= 11'd0;
            r_up_rmask    <= 11'd0;
            r_fire_dlv    <= 1'b0;
            r_dz_valid    <= 1'b0;
            for (int i = 0; i < pbaxc_pkg::N_AXES; i++) begin
                r_pub_axes[i]   <= 16'd0;
                r_frame_axes[i] <= 16'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pbaxc_pkg::CFG_LOOK_SCALE:  r_look_scale  <= i_cfg_data[15:0];
                    pbaxc_pkg::CFG_LOOK_EXPO:   r_look_expo   <= i_cfg_data;
                    pbaxc_pkg::CFG_FIRE_STICKY: r_fire_sticky <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_pub_level   <= n_pub_level;
            r_pend_down   <= n_pend_down;
            r_pend_up     <= n_pend_up;
            r_prev_level  <= n_prev_level;
            r_frame_level <= n_frame_level;
            r_down_latch  <= n_down_latch;
            r_up_latch    <= n_up_latch;
            r_down_rmask  <= n_down_rmask;
            r_up_rmask    <= n_up_rmask;
            r_fire_dlv    <= n_fire_dlv;
            r_dz_valid    <= i_cmd.dz_issue;
            for (int i = 0; i < pbaxc_pkg::N_AXES; i++) begin
                r_pub_axes[i]   <= n_pub_axes[i];
                r_frame_axes[i] <= n_frame_axes[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        r_dz_prod    <= dz_prod;
        r_dz_zero    <= (dz_mag < pbaxc_pkg::DZ_THRESH) || !r_item.enabled;
        r_dz_neg     <= dz_raw[15];
        r_dz_idx     <= i_cmd.dz_sel;
        r_lk_a       <= lk_mag;
        r_lk_neg     <= lk_v[15];
        r_lk_ome     <= pbaxc_pkg::EXPO_ONE - lk_e;
        r_lk_ea      <= 33'(lk_e) * 33'(lk_mag);
        r_lk_bracket <= {r_lk_ome[16:0], 15'd0} + r_lk_ea[31:0];
        r_lk_p2      <= lk_prod2[47:16];
        r_lk_p3      <= lk_prod3[47:27];
        if (i_cmd.btn_query) begin
            r_out.flag       <= btn_flag;
            r_out.axis_value <= 16'sd0;
        end else if (i_cmd.ax_out) begin
            r_out.flag       <= 1'b0;
            r_out.axis_value <= axis_res;
        end
    end

    assign o_out_data = r_out;

`ifndef ASSERT_OFF
    a_read_mask_in_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_down_rmask & ~r_down_latch) == 11'd0) && ((r_up_rmask & ~r_up_latch) == 11'd0))
        else $error("read mask marks a latch bit that is not set");

    a_fire_from_down_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fire_dlv) |-> $past(i_cmd.btn_query && r_item.op == pbaxc_pkg::OP_QDOWN
                                    && r_item.input_index == pbaxc_pkg::FIRE_BUTTON))
        else $error("fire delivered set without a down query of fire");

    a_axes_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pub_axes[0] != 16'h8000) && (r_pub_axes[1] != 16'h8000)
        && (r_pub_axes[2] != 16'h8000) && (r_pub_axes[3] != 16'h8000))
        else $error("conditioned axis escaped the clamp");
`endif

endmodule

FILE: rtl/core/pad_button_latch_axis_conditioner.sv
// Gamepad conditioner. One item is taken at a time: a publish sends the four stick axes
// one a cycle through a single reciprocal multiplier for the dead-zone rescale, then the
// button level commits, and an axis query passes through the three registered multiplies
// of the view-axis expo and scale path. A result beat sits in an output register, so a new
// item is taken while it waits; a query only stalls when the previous result has not yet
// been taken. Configuration writes are always ready and are meant for idle periods.
module pad_button_latch_axis_conditioner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pbaxc_pkg::t_in_item   i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pbaxc_pkg::t_out_item  o_out_data,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [16:0]           i_cfg_data
);

    pbaxc_pkg::t_cmd cmd;
    logic            cfg_we;

    // register writes never back-pressure
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer: decodes the op on acceptance and steps the datapath
    pbaxc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.op),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // dead zone, edge latches, frame snapshot, view axis shaping, result register
    pbaxc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/pad_answer_checker.sv
module pad_answer_checker
    import pbaxc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DZ_EDGE  = 5243;
    localparam longint Q15_FULL = 32768;
    localparam longint Q15_MAX  = 32767;
    localparam longint EXPO_MAX = 65536;

    // register copies
    logic [15:0] scale_q12;
    logic [16:0] expo_q16;
    logic        sticky_fire;

    // button and axis state
    logic [10:0] pub_level, pend_down, pend_up, prev_level, frm_level;
    logic [10:0] down_latch, up_latch, down_read, up_read;
    logic        fire_seen;
    logic signed [15:0] pub_axes [N_AXES];
    logic signed [15:0] frm_axes [N_AXES];

    t_out_item answers_due [$];

    function automatic logic signed [15:0] dz_rescale(input logic signed [15:0] raw);
        longint mag, r;
        mag = (raw < 0) ? -longint'(raw) : longint'(raw);
        if (mag < DZ_EDGE) return '0;
        r = (mag - DZ_EDGE) * Q15_FULL / (Q15_FULL - DZ_EDGE);
        if (r > Q15_MAX) r = Q15_MAX;
        return (raw < 0) ? 16'(-r) : 16'(r);
    endfunction

    function automatic logic signed [15:0] view_shape(input logic signed [15:0] v);
        longint mag, ex, blend, r;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        ex = (longint'(expo_q16) > EXPO_MAX) ? EXPO_MAX : longint'(expo_q16);
        blend = (EXPO_MAX - ex) * Q15_FULL + ex * mag;
        r = (((mag * blend) >> 16) * longint'(scale_q12)) >> 27;
        if (r > Q15_MAX) r = Q15_MAX;
        return (v < 0) ? 16'(-r) : 16'(r);
    endfunction

    task automatic clear_model();
        scale_q12   = LOOK_SCALE_RST;
        expo_q16    = LOOK_EXPO_RST;
        sticky_fire = FIRE_STICKY_RST;
        pub_level   = '0;
        pend_down   = '0;
        pend_up     = '0;
        prev_level  = '0;
        frm_level   = '0;
        down_latch  = '0;
        up_latch    = '0;
        down_read   = '0;
        up_read     = '0;
        fire_seen   = 1'b0;
        for (int a = 0; a < N_AXES; a++) begin
            pub_axes[a] = '0;
            frm_axes[a] = '0;
        end
        answers_due.delete();
    endtask

    task automatic condition_item(input t_in_item it);
        t_out_item   ans;
        logic [10:0] lvl, rise, fall;
        logic        btn;
        btn = (it.input_index <= LAST_BUTTON);
        ans = '0;
        case (it.op)
            OP_PUBLISH: begin
                lvl = it.enabled ? it.button_level : '0;
                pub_axes[0] = it.enabled ? dz_rescale(it.left_x) : '0;
                pub_axes[1] = it.enabled ? dz_rescale(it.left_y) : '0;
                pub_axes[2] = it.enabled ? dz_rescale(it.right_x) : '0;
                pub_axes[3] = it.enabled ? dz_rescale(it.right_y) : '0;
                pend_down |= lvl & ~pub_level;
                pend_up   |= pub_level & ~lvl;
                pub_level  = lvl;
            end
            OP_FRAME: begin
                rise = pend_down | (pub_level & ~prev_level);
                fall = pend_up | (prev_level & ~pub_level);
                frm_level  = pub_level;
                pend_down  = '0;
                pend_up    = '0;
                down_latch = (down_latch & ~down_read) | rise;
                up_latch   = (up_latch & ~up_read) | fall;
                down_read  = '0;
                up_read    = '0;
                prev_level = pub_level;
                for (int a = 0; a < N_AXES; a++) frm_axes[a] = pub_axes[a];
            end
            OP_QDOWN: begin
                if (btn && down_latch[it.input_index]) begin
                    down_read[it.input_index] = 1'b1;
                    if (it.input_index == FIRE_BUTTON) fire_seen = 1'b1;
                    ans.flag = 1'b1;
                end
                answers_due.push_back(ans);
            end
            OP_QUP: begin
                if (btn && up_latch[it.input_index]) begin
                    up_read[it.input_index] = 1'b1;
                    ans.flag = 1'b1;
                end else if (it.input_index == FIRE_BUTTON && sticky_fire && fire_seen
                             && !frm_level[FIRE_BUTTON]) begin
                    // fire release held up while the trigger stays idle
                    ans.flag = 1'b1;
                end
                answers_due.push_back(ans);
            end
            OP_QAXIS: begin
                case (it.input_index)
                    AXIS_LX: ans.axis_value = frm_axes[0];
                    AXIS_LY: ans.axis_value = -frm_axes[1];
                    AXIS_RX: ans.axis_value = view_shape(frm_axes[2]);
                    AXIS_RY: ans.axis_value = view_shape(frm_axes[3]);
                    default: ans.axis_value = '0;
                endcase
                answers_due.push_back(ans);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n !== 1'b1) begin
            clear_model();
        end else begin
            // answers first: an item taken at this edge cannot answer at it
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected answer beat flag %0b axis %0d",
                                 $realtime, i_out_data.flag, i_out_data.axis_value);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_out_data.flag !== want.flag
                        || i_out_data.axis_value !== want.axis_value) begin
                        if (o_fail_count < 10)
                            $display({"%0t: answer mismatch flag exp %0b got %0b,",
                                      " axis exp %0d got %0d"},
                                     $realtime, want.flag, i_out_data.flag,
                                     want.axis_value, i_out_data.axis_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) condition_item(i_in_data);
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    CFG_LOOK_SCALE:  scale_q12   = i_cfg_data[15:0];
                    CFG_LOOK_EXPO:   expo_q16    = i_cfg_data;
                    CFG_FIRE_STICKY: sticky_fire = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending = answers_due.size();
    end

endmodule

FILE: tb/tb.sv
module tb;
    import pbaxc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int PHASES     = 7;
    localparam int PHASE_BEATS = 150;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    t_in_item    item_beat;
    logic        ans_valid;
    logic        ans_stall;
    t_out_item   ans_beat;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    int fail_count;
    int pending;

    // random gaps on each side, switched per stretch of the run
    logic in_idle_en;
    logic out_idle_en;

    // button level carried between publishes so edges stay sparse
    logic [10:0] held_buttons;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pad_button_latch_axis_conditioner dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (item_valid),
        .o_in_stall (item_stall),
        .i_in_data  (item_beat),
        .o_out_valid(ans_valid),
        .i_out_stall(ans_stall),
        .o_out_data (ans_beat),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // watches all three channels, predicts answers and compares them
    pad_answer_checker answer_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (item_valid),
        .i_in_stall  (item_stall),
        .i_in_data   (item_beat),
        .i_out_valid (ans_valid),
        .i_out_stall (ans_stall),
        .i_out_data  (ans_beat),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // answer side back-pressure: bursts of stall, none when disabled
    initial begin
        ans_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (out_idle_en && $urandom_range(0, 7) == 0) begin
                ans_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                ans_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_item item_of(input logic [2:0] op,
                                         input logic signed [15:0] lx,
                                         input logic signed [15:0] ly,
                                         input logic signed [15:0] rx,
                                         input logic signed [15:0] ry,
                                         input logic [10:0] lvl,
                                         input logic en,
                                         input logic [3:0] idx);
        t_in_item it;
        it.op           = op;
        it.left_x       = lx;
        it.left_y       = ly;
        it.right_x      = rx;
        it.right_y      = ry;
        it.button_level = lvl;
        it.enabled      = en;
        it.input_index  = idx;
        return it;
    endfunction

    // mostly full range, with a share of corners and values around the dead zone
    function automatic logic signed [15:0] pick_axis();
        logic signed [15:0] v;
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) begin
            case ($urandom_range(0, 6))
                0: v = 16'sh8000;
                1: v = 16'sd32767;
                2: v = 16'sd5243;
                3: v = 16'sd5242;
                4: v = 16'sd5244;
                5: v = 16'sd0;
                default: v = 16'sd32766;
            endcase
        end else if (k < 4) begin
            v = 16'($urandom_range(0, 6000));
        end else begin
            v = 16'($urandom);
        end
        if (k < 4 && $urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    function automatic t_in_item make_item();
        t_in_item it;
        int w;
        it.left_x  = pick_axis();
        it.left_y  = pick_axis();
        it.right_x = pick_axis();
        it.right_y = pick_axis();
        case ($urandom_range(0, 4))
            0: held_buttons = 11'($urandom);
            1, 2: held_buttons[$urandom_range(0, 10)] ^= 1'b1;
            3: held_buttons = held_buttons ^ 11'(1 << $urandom_range(0, 10))
                                           ^ 11'(1 << $urandom_range(0, 10));
            default: begin
            end
        endcase
        it.button_level = held_buttons;
        it.enabled      = ($urandom_range(0, 9) != 0);
        it.input_index  = 4'($urandom_range(0, 15));
        w = $urandom_range(0, 99);
        if (w < 28)      it.op = OP_PUBLISH;
        else if (w < 45) it.op = OP_FRAME;
        else if (w < 62) it.op = OP_QDOWN;
        else if (w < 79) it.op = OP_QUP;
        else if (w < 96) it.op = OP_QAXIS;
        else             it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (it.op == OP_QDOWN || it.op == OP_QUP) begin
            // fire button gets extra weight for the sticky release rule
            w = $urandom_range(0, 9);
            if (w < 3)       it.input_index = FIRE_BUTTON;
            else if (w < 9)  it.input_index = 4'($urandom_range(0, LAST_BUTTON));
            else             it.input_index = 4'($urandom_range(AXIS_LX, 15));
        end else if (it.op == OP_QAXIS && $urandom_range(0, 9) < 8) begin
            it.input_index = 4'($urandom_range(AXIS_LX, AXIS_RY));
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic push_item(input t_in_item it);
        if (in_idle_en && $urandom_range(0, 5) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_beat  <= it;
        do @(posedge clk); while (item_stall !== 1'b0);
        @(negedge clk);
    endtask

    // one register beat; valid is left high for a following beat
    task automatic put_reg(input logic [1:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [15:0] scale, input logic [16:0] expo,
                            input logic sticky);
        put_reg(CFG_LOOK_SCALE, 17'(scale));
        put_reg(CFG_LOOK_EXPO, expo);
        put_reg(CFG_FIRE_STICKY, 17'(sticky));
        cfg_valid <= 1'b0;
    endtask

    // wait for every answer, then let a slow axis query run out
    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    initial begin
        t_in_item it;
        int sent;
        int mode;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_beat    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LOOK_SCALE;
        cfg_data     = '0;
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        held_buttons = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under reset register values
        // full-scale and dead-zone-edge axes, every button pressed
        push_item(item_of(OP_PUBLISH, 16'sd32767, 16'sh8000, 16'sd5243, -16'sd5242,
                          11'h7ff, 1'b1, 4'd0));
        push_item(item_of(OP_FRAME, '0, '0, '0, '0, '0, 1'b0, 4'd0));
        push_item(item_of(OP_QDOWN, '0, '0, '0, '0, '0, 1'b0, FIRE_BUTTON));
        push_item(item_of(OP_QDOWN, '0, '0, '0, '0, '0, 1'b0, LAST_BUTTON));
        // button query past the last button
        push_item(item_of(OP_QDOWN, '0, '0, '0, '0, '0, 1'b0, 4'd15));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_LX));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_LY));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_RX));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_RY));
        // axis query on non-axis indexes
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, 4'd15));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, 4'd3));
        // release everything; up query before the frame sees nothing yet
        push_item(item_of(OP_PUBLISH, -16'sd32767, 16'sd0, 16'sd32767, -16'sd32767,
                          11'h000, 1'b1, 4'd0));
        push_item(item_of(OP_QUP, '0, '0, '0, '0, '0, 1'b0, FIRE_BUTTON));
        push_item(item_of(OP_FRAME, '0, '0, '0, '0, '0, 1'b0, 4'd0));
        push_item(item_of(OP_QUP, '0, '0, '0, '0, '0, 1'b0, FIRE_BUTTON));
        push_item(item_of(OP_QUP, '0, '0, '0, '0, '0, 1'b0, 4'd5));
        push_item(item_of(OP_QUP, '0, '0, '0, '0, '0, 1'b0, AXIS_LY));
        // latch bits read above clear on this frame; fire release then holds by stickiness
        push_item(item_of(OP_FRAME, '0, '0, '0, '0, '0, 1'b0, 4'd0));
        push_item(item_of(OP_QUP, '0, '0, '0, '0, '0, 1'b0, FIRE_BUTTON));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_RX));
        push_item(item_of(OP_QAXIS, '0, '0, '0, '0, '0, 1'b0, AXIS_RY));
        // unused op codes are dropped
        push_item(item_of(OP_SPARE_LO, 16'sd100, '0, '0, '0, 11'h7ff, 1'b1, 4'd0));
        push_item(item_of(OP_SPARE_HI, '0, '0, '0, '0, '0, 1'b1, 4'd15));
        // disabled publish forces released buttons and centred axes
        push_item(item_of(OP_PUBLISH, 16'sd20000, -16'sd20000, 16'sd30000, 16'sd9000,
                          11'h7ff, 1'b0, 4'd0));
        push_item(item_of(OP_FRAME, '0, '0, '0, '0, '0, 1'b0, 4'd0));
        push_item(item_of(OP_QDOWN, '0, '0, '0, '0, '0, 1'b0, 4'd3));
        drain();

        // random part, one register setting per phase, extremes included
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_regs(LOOK_SCALE_RST, LOOK_EXPO_RST, FIRE_STICKY_RST);
                1: set_regs(16'd0, 17'd0, 1'b0);
                2: set_regs(16'hffff, EXPO_ONE, 1'b1);
                3: set_regs(16'hffff, 17'h1ffff, 1'b0);   // expo above one saturates
                4: set_regs(16'd4096, 17'd0, 1'b1);
                5: set_regs(16'($urandom), 17'($urandom), 1'($urandom));
                default: set_regs(16'($urandom_range(1, 16384)), 17'($urandom_range(0, 65536)),
                                  1'b1);
            endcase
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if (sent % 40 == 0) begin
                    // the last phase runs with no gaps on either side
                    mode = (p == PHASES - 1) ? 0 : $urandom_range(0, 3);
                    in_idle_en  = mode[0];
                    out_idle_en = mode[1];
                end
                it = make_item();
                push_item(it);
                if (it.op <= OP_QAXIS) sent++;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
